### hdl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants for the rotated substring checker.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // width of one character
  localparam int CHAR_W = 8;

  // bit positions of the result fields in m_tdata
  localparam int RES_MATCH_BIT = 0;
  localparam int RES_OVF_BIT   = 1;
  localparam int RES_W         = 8;

  // status from the search sequencer to the top level
  typedef struct packed {
    logic done;
    logic hit;
  } srch_status_t;

endpackage

### hdl/rsc_ram.sv
// ----------------------------------------------------------------------------
// rsc_ram
// Character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsc_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rsc_pkg::CHAR_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [rsc_pkg::CHAR_W-1:0] rdata
);

  logic [rsc_pkg::CHAR_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/rsc_search.sv
// ----------------------------------------------------------------------------
// rsc_search
// Search sequencer: walks every rotation start of the text and compares the
// pattern one character at a time, reading both stores and comparing the
// returned data in the following cycle.
// ----------------------------------------------------------------------------
module rsc_search #(
  parameter int AW = 5,
  parameter int LW = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [LW-1:0]              txt_len,
  input  logic [LW-1:0]              pat_len,
  input  logic                       ack,
  input  logic [rsc_pkg::CHAR_W-1:0] txt_rdata,
  input  logic [rsc_pkg::CHAR_W-1:0] pat_rdata,
  output logic [AW-1:0]              txt_addr,
  output logic [AW-1:0]              pat_addr,
  output rsc_pkg::srch_status_t      status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state;
  logic [LW-1:0] n;
  logic [LW-1:0] m;
  logic [AW-1:0] shift;
  logic [AW-1:0] k;
  logic [AW-1:0] tpos;
  logic          hit;

  // last pattern character, text wrap and last rotation detection
  logic k_last;
  logic tpos_wrap;
  logic shift_last;
  assign k_last     = (LW'(k) + LW'(1)) == m;
  assign tpos_wrap  = (LW'(tpos) + LW'(1)) == n;
  assign shift_last = (LW'(shift) + LW'(1)) == n;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hit   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            n     <= txt_len;
            m     <= pat_len;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          shift <= '0;
          k     <= '0;
          tpos  <= '0;
          if (m == '0) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (txt_rdata == pat_rdata) begin
            if (k_last) begin
              hit   <= 1'b1;
              state <= S_DONE;
            end else begin
              k     <= k + AW'(1);
              tpos  <= tpos_wrap ? '0 : tpos + AW'(1);
              state <= S_READ;
            end
          end else if (shift_last) begin
            hit   <= 1'b0;
            state <= S_DONE;
          end else begin
            shift <= shift + AW'(1);
            tpos  <= shift + AW'(1);
            k     <= '0;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign txt_addr    = tpos;
  assign pat_addr    = k;
  assign status.done = (state == S_DONE);
  assign status.hit  = hit;

endmodule

### hdl/rotated_substring_check.sv
// Search: after the closing character of the second string the result is
//   registered; each compare is one store read plus one compare, and an empty
//   shorter string reports a match without any compare.
// Throughput: one character per cycle while loading; no request is taken
//   from the closing character until its result sits in the output register.
// Reset: synchronous, clears lengths, flags and sequencer; stores keep data.
// ----------------------------------------------------------------------------
// rotated_substring_check
// Loads two strings into character stores and reports whether the shorter
// one occurs in some rotation of the longer one, and flags dropped characters.
// ----------------------------------------------------------------------------
module rotated_substring_check #(
  parameter int MAX_LEN = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // char_code
  input  logic                     s_tuser,   // string_select
  input  logic                     s_tlast,   // last_char
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [rsc_pkg::RES_W-1:0] m_tdata   // match_found, overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);

  logic [LW-1:0] len_a;
  logic [LW-1:0] len_b;
  logic          overflow_seen;
  logic          busy;
  logic          ovf_hold;
  logic          text_is_first;
  logic          match;
  logic          ovf_out;

  logic                       accept;
  logic                       we_a;
  logic                       we_b;
  logic                       start;
  logic [LW-1:0]              len_b_next;
  logic [AW-1:0]              txt_addr;
  logic [AW-1:0]              pat_addr;
  logic [rsc_pkg::CHAR_W-1:0] rdata_a;
  logic [rsc_pkg::CHAR_W-1:0] rdata_b;
  logic                       ack;
  rsc_pkg::srch_status_t      status;

  // input request decode
  assign s_tready   = !busy;
  assign accept     = s_tvalid && s_tready;
  assign we_a       = accept && !s_tuser && (len_a < MAX_L);
  assign we_b       = accept && s_tuser && (len_b < MAX_L);
  assign len_b_next = we_b ? len_b + LW'(1) : len_b;
  assign start      = accept && s_tuser && s_tlast;

  // lengths, overflow and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a         <= '0;
      len_b         <= '0;
      overflow_seen <= 1'b0;
      busy          <= 1'b0;
    end else if (start) begin
      len_a         <= '0;
      len_b         <= '0;
      overflow_seen <= 1'b0;
      busy          <= 1'b1;
    end else begin
      if (we_a) begin
        len_a <= len_a + LW'(1);
      end
      if (we_b) begin
        len_b <= len_b + LW'(1);
      end
      if (accept && !we_a && !we_b) begin
        overflow_seen <= 1'b1;
      end
      if (status.done && ack) begin
        busy <= 1'b0;
      end
    end
  end

  // pair decision captured at the closing character
  always_ff @(posedge clk) begin
    if (start) begin
      text_is_first <= (len_a > len_b_next);
      ovf_hold      <= overflow_seen || !we_b;
    end
  end

  rsc_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (len_a[AW-1:0]),
    .wdata (s_tdata),
    .raddr (text_is_first ? txt_addr : pat_addr),
    .rdata (rdata_a)
  );

  rsc_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (len_b[AW-1:0]),
    .wdata (s_tdata),
    .raddr (text_is_first ? pat_addr : txt_addr),
    .rdata (rdata_b)
  );

  rsc_search #(.AW(AW), .LW(LW)) u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .txt_len   ((len_a > len_b_next) ? len_a : len_b_next),
    .pat_len   ((len_a > len_b_next) ? len_b_next : len_a),
    .ack       (ack),
    .txt_rdata (text_is_first ? rdata_a : rdata_b),
    .pat_rdata (text_is_first ? rdata_b : rdata_a),
    .txt_addr  (txt_addr),
    .pat_addr  (pat_addr),
    .status    (status)
  );

  // output register
  assign ack = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status.done && ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done && ack) begin
      match   <= status.hit;
      ovf_out <= ovf_hold;
    end
  end

  always_comb begin
    m_tdata                         = '0;
    m_tdata[rsc_pkg::RES_MATCH_BIT] = match;
    m_tdata[rsc_pkg::RES_OVF_BIT]   = ovf_out;
  end

endmodule

### hdl/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks for the rotated substring checker, bound to the top.
// ----------------------------------------------------------------------------
module rsc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      s_tuser,
  input logic                      s_tlast,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rsc_pkg::RES_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // closing request blocks input while the search runs
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser && s_tlast |=> !s_tready)
    else $error("input taken right after closing request");

  // unused result bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[rsc_pkg::RES_W-1:2] == '0))
    else $error("result padding not zero");

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind rotated_substring_check rsc_checker u_rsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
